FILE: rtl/number_to_led_digit_commands_defines.svh
// assertion macros for the number to led digit commands block
// included by the top level; define NO_ASSERTIONS to drop the checks
`ifndef NUMBER_TO_LED_DIGIT_COMMANDS_DEFINES_SVH
`define NUMBER_TO_LED_DIGIT_COMMANDS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition must hold on every clock outside reset
`define N2L_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("n2l check failed");

// antecedent implies consequent in the next cycle
`define N2L_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("n2l sequence check failed");

`else

`define N2L_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define N2L_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/n2l_pkg.sv
// shared types, constants and the digit helper for the led digit command block
// no dependencies
package n2l_pkg;

    localparam int NUM_DIGITS_DEFAULT = 8;

    localparam logic [3:0]  ADDR_TEST   = 4'hF;
    localparam logic [3:0]  ADDR_DECODE = 4'h9;
    localparam logic [3:0]  ADDR_DIGIT0 = 4'h1;
    localparam logic [7:0]  DATA_TEST   = 8'h00;
    localparam logic [7:0]  DATA_DECODE = 8'hFF;
    localparam logic [3:0]  CODE_BLANK  = 4'hF;

    // ceil(2^35 / 10): q = (x * RECIP_TEN) >> 35 is exact for every 32-bit x
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // word positions at the start of each run
    localparam int CMD_TEST   = 0;
    localparam int CMD_DECODE = 1;
    localparam int CMD_DIGIT0 = 2;

    // one pipeline slot: remaining quotient, quotient before it, point mask
    typedef struct packed {
        logic [31:0] cur;
        logic [31:0] prv;
        logic [7:0]  mask;
    } stage_t;

    // digit from a value and its quotient by ten; blank once the value is zero, unless first is set
    function automatic logic [3:0] digit_code(input logic [31:0] prv,
                                              input logic [31:0] cur,
                                              input logic        first);
        logic [3:0] ten_q;
        logic [3:0] rem;
        ten_q = {cur[0], 3'b000} + {cur[2:0], 1'b0};
        rem   = prv[3:0] - ten_q;
        if (!first && (prv == 32'd0))
            digit_code = CODE_BLANK;
        else
            digit_code = rem;
    endfunction

endpackage

FILE: rtl/n2l_div_stage.sv
// one divide-by-ten pipeline stage: reciprocal multiply and the digit it completes
// depends on n2l_pkg
module n2l_div_stage
    import n2l_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT,
    parameter int STAGE      = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  stage_t                     in_data,
    input  logic [NUM_DIGITS-1:0][3:0] in_codes,
    output logic                       out_valid,
    output stage_t                     out_data,
    output logic [NUM_DIGITS-1:0][3:0] out_codes
);

    logic [63:0]                product;
    stage_t                     data_next;
    logic [NUM_DIGITS-1:0][3:0] codes_next;
    logic                       valid_reg;
    stage_t                     data_reg;
    logic [NUM_DIGITS-1:0][3:0] codes_reg;

    assign product = {32'd0, in_data.cur} * {32'd0, RECIP_TEN};

    always_comb
    begin
        data_next.cur  = {3'b000, product[63:RECIP_SHIFT]};
        data_next.prv  = in_data.cur;
        data_next.mask = in_data.mask;
    end

    // the quotient pair arriving here completes digit STAGE-2
    if (STAGE >= 2)
    begin : g_digit
        always_comb
        begin
            codes_next = in_codes;
            codes_next[STAGE-2] = digit_code(in_data.prv, in_data.cur, STAGE == 2);
        end
    end
    else
    begin : g_pass
        always_comb
        begin
            codes_next = in_codes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg  <= data_next;
            codes_reg <= codes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_codes = codes_reg;

endmodule

FILE: rtl/n2l_serializer.sv
// command serialiser: holds one finished number and sends its run of words
// depends on n2l_pkg
module n2l_serializer
    import n2l_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  stage_t                     in_data,
    input  logic [NUM_DIGITS-1:0][3:0] in_codes,
    output logic                       in_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // reg_address[3:0], reg_data[11:4], command_word[27:12]
    output logic                       m_tlast
);

    localparam int CNT_W = $clog2(NUM_DIGITS + 2);
    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_DIGITS + 1);

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [NUM_DIGITS-1:0][3:0] codes_reg;
    logic [NUM_DIGITS-1:0]      mask_reg;
    logic [NUM_DIGITS-1:0][3:0] codes_next;
    logic                       load;
    logic                       at_last;
    logic [CNT_W-1:0]           dig;
    logic [IDX_W-1:0]           idx;
    logic [3:0]                 reg_address;
    logic [7:0]                 reg_data;

    assign at_last  = (cnt_reg == LAST_CNT);
    assign in_ready = !busy_reg || (m_tready && at_last);
    assign load     = in_valid && in_ready;

    // top digit is finished here from the last quotient pair
    always_comb
    begin
        codes_next = in_codes;
        codes_next[NUM_DIGITS-1] = digit_code(in_data.prv, in_data.cur, NUM_DIGITS == 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= codes_next;
            mask_reg  <= in_data.mask[NUM_DIGITS-1:0];
        end
    end

    assign dig = cnt_reg - CNT_W'(CMD_DIGIT0);
    assign idx = dig[IDX_W-1:0];

    always_comb
    begin
        if (cnt_reg == CNT_W'(CMD_TEST))
        begin
            reg_address = ADDR_TEST;
            reg_data    = DATA_TEST;
        end
        else if (cnt_reg == CNT_W'(CMD_DECODE))
        begin
            reg_address = ADDR_DECODE;
            reg_data    = DATA_DECODE;
        end
        else
        begin
            reg_address = ADDR_DIGIT0 + 4'(dig);
            reg_data    = {mask_reg[idx], 3'b000, codes_reg[idx]};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = at_last;
    assign m_tdata  = {8'h00, reg_address, reg_data, reg_data, reg_address};

endmodule

FILE: rtl/number_to_led_digit_commands.sv
// path: a number passes the input register, the divide stages and the serialiser
// register before its first command word is valid; throughput is set by the output
// port, one command word per cycle while m_tready is high; the divide pipeline takes
// a number every cycle unless its full last stage waits on the serialiser; reset:
// asynchronous, clears pipeline valid bits and serialiser, no clearing pass, s_tready at once
`include "number_to_led_digit_commands_defines.svh"

module number_to_led_digit_commands
    import n2l_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // number[31:0], point_mask[39:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // reg_address[3:0], reg_data[11:4], command_word[27:12]
    output logic        m_tlast
);

    // digit count held to the one to eight the display has
    localparam int DIGITS_USED = (NUM_DIGITS < 1) ? 1 : ((NUM_DIGITS > 8) ? 8 : NUM_DIGITS);

    logic                        valid_pipe [0:DIGITS_USED];
    stage_t                      data_pipe  [0:DIGITS_USED];
    logic [DIGITS_USED-1:0][3:0] codes_pipe [0:DIGITS_USED];
    logic                        in_valid_reg;
    stage_t                      in_data_reg;
    stage_t                      in_data_next;
    logic                        ser_ready;
    logic                        advance;
    logic                        pipe_full;
    logic                        out_fire;

    assign pipe_full = valid_pipe[DIGITS_USED];
    assign out_fire  = m_tvalid && m_tready;

    // whole pipeline moves together; a bubble at the end lets it move under a stall
    assign advance  = !pipe_full || ser_ready;
    assign s_tready = advance;

    always_comb
    begin
        in_data_next.cur  = s_tdata[31:0];
        in_data_next.prv  = 32'd0;
        in_data_next.mask = s_tdata[39:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            in_data_reg <= in_data_next;
    end

    assign valid_pipe[0] = in_valid_reg;
    assign data_pipe[0]  = in_data_reg;
    assign codes_pipe[0] = '0;

    for (genvar s = 1; s <= DIGITS_USED; s++)
    begin : g_stage
        n2l_div_stage #(
            .NUM_DIGITS (DIGITS_USED),
            .STAGE      (s)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_pipe[s-1]),
            .in_data   (data_pipe[s-1]),
            .in_codes  (codes_pipe[s-1]),
            .out_valid (valid_pipe[s]),
            .out_data  (data_pipe[s]),
            .out_codes (codes_pipe[s])
        );
    end

    n2l_serializer #(
        .NUM_DIGITS (DIGITS_USED)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_full),
        .in_data  (data_pipe[DIGITS_USED]),
        .in_codes (codes_pipe[DIGITS_USED]),
        .in_ready (ser_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a run is never broken once started
    `N2L_ASSERT_NEXT(a_run_unbroken, clk, rst_n, out_fire && !m_tlast, m_tvalid)
    // with nothing finished behind it the serialiser falls idle after the last word
    `N2L_ASSERT_NEXT(a_idle_after_run, clk, rst_n, out_fire && m_tlast && !pipe_full, !m_tvalid)
    // the last word of a run addresses the top digit
    `N2L_ASSERT_HOLDS(a_last_addr, clk, rst_n, !m_tlast || m_tdata[3:0] == 4'(DIGITS_USED))

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for number_to_led_digit_commands: random and directed numbers in, command words checked
// depends on n2l_pkg and the block itself; stalls and gaps on both stream sides
module tb_top;
    import n2l_pkg::*;

    localparam int DIGITS     = NUM_DIGITS_DEFAULT;
    localparam int SHOWN      = (DIGITS < 1) ? 1 : ((DIGITS > 8) ? 8 : DIGITS);
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_LEN  = 113;

    typedef struct packed {
        logic [3:0]  address;
        logic [7:0]  data;
        logic [15:0] word;
        logic        last;
    } led_cmd_t;

    class command_tracker;
        led_cmd_t pending_cmds[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void report(string msg);
            if (mismatches < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endfunction

        function led_cmd_t make_cmd(logic [3:0] address, logic [7:0] data, logic last);
            led_cmd_t c;
            c.address = address;
            c.data    = data;
            c.word    = {4'h0, address, data};
            c.last    = last;
            return c;
        endfunction

        // works out the whole run of command words for one number
        function void note_number(logic [31:0] num, logic [7:0] mask);
            logic [31:0] rest;
            logic [7:0]  code;
            rest = num;
            pending_cmds.push_back(make_cmd(ADDR_TEST, DATA_TEST, 1'b0));
            pending_cmds.push_back(make_cmd(ADDR_DECODE, DATA_DECODE, 1'b0));
            for (int i = 0; i < SHOWN; i++)
            begin
                // digit 0 always shows a numeral, higher ones blank once nothing is left
                if (i != 0 && rest == 32'd0)
                    code = {4'h0, CODE_BLANK};
                else
                    code = 8'(rest % 10);
                if (mask[i])
                    code[7] = 1'b1;
                pending_cmds.push_back(make_cmd(ADDR_DIGIT0 + 4'(i), code, i == SHOWN - 1));
                rest = rest / 10;
            end
        endfunction

        function void check_command(logic [31:0] tdata, logic tlast);
            led_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                report($sformatf("word %h arrived with nothing expected", tdata));
                return;
            end
            want = pending_cmds.pop_front();
            if (tdata[3:0] !== want.address)
                report($sformatf("reg_address %h, expected %h", tdata[3:0], want.address));
            if (tdata[11:4] !== want.data)
                report($sformatf("reg_data %h, expected %h", tdata[11:4], want.data));
            if (tdata[27:12] !== want.word)
                report($sformatf("command_word %h, expected %h", tdata[27:12], want.word));
            if (tdata[31:28] !== 4'h0)
                report($sformatf("padding bits %b not zero", tdata[31:28]));
            if (tlast !== want.last)
                report($sformatf("last %b, expected %b", tlast, want.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    command_tracker board = new();

    number_to_led_digit_commands #(
        .NUM_DIGITS (DIGITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // both sides sampled at the edge, before any update of this step
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_number(s_tdata[31:0], s_tdata[39:32]);
        if (rst_n && m_tvalid && m_tready)
            board.check_command(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // valid stays high between back-to-back words, lowered only for a gap
    task automatic send_number(input logic [31:0] num, input logic [7:0] mask);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mask, num};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin
        logic [31:0] num;
        int          ndig;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, blanking, points on blank digits, dropped high digits
        send_number(32'd0, 8'h00);
        send_number(32'd0, 8'hFF);
        send_number(32'd1, 8'h01);
        send_number(32'd9, 8'h80);
        send_number(32'd7, 8'hFE);
        send_number(32'd10, 8'hAA);
        send_number(32'd99, 8'h55);
        send_number(32'd100, 8'h0F);
        send_number(32'd12, 8'hFF);
        send_number(32'd12345678, 8'hF0);
        send_number(32'd90000009, 8'h00);
        send_number(32'd10000000, 8'h80);
        send_number(32'd99999999, 8'hFF);
        send_number(32'd100000000, 8'h00);
        send_number(32'd1000000000, 8'h01);
        send_number(32'h8000_0000, 8'hAA);
        send_number(32'hFFFF_FFFF, 8'hFF);
        send_number(32'hFFFF_FFFF, 8'h00);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 64; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 64; end
                default: begin send_gap_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                case ($urandom_range(3))
                    0: num = $urandom;
                    1:
                    begin
                        // a given count of decimal digits, so blanking starts anywhere
                        ndig = $urandom_range(1, 8);
                        num  = $urandom_range(0, 10 ** ndig - 1);
                    end
                    2: num = $urandom_range(100000000, 32'hFFFF_FFFF);
                    default: num = $urandom_range(0, 20);
                endcase
                send_number(num, 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SHOWN + 8) @(posedge clk);

        if (board.mismatches == 0 && board.pending_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
